>>> design/weighted_neighbor_cluster_vote_core_macros.svh
// assertion helpers for the vote core queue
`ifndef WEIGHTED_NEIGHBOR_CLUSTER_VOTE_CORE_MACROS_SVH
`define WEIGHTED_NEIGHBOR_CLUSTER_VOTE_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define WNCV_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("wncv assertion failed");

// next-cycle implication, checked outside reset
`define WNCV_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("wncv assertion failed");

`endif

>>> design/wncv_pkg.sv
`timescale 1ns / 1ps

package wncv_pkg;

    localparam int MAX_NEIGHBORS = 4;
    localparam int MAX_CLUSTERS  = 1024;
    localparam int QUEUE_DEPTH   = 2;

    localparam int CL_W     = 10;
    localparam int DIST_W   = 16;
    localparam int SQ_W     = 2 * DIST_W;
    localparam int WEIGHT_W = 32;
    localparam int TALLY_W  = 34;

    // weight = floor(2^WEIGHT_SHIFT / d^2)
    localparam int WEIGHT_SHIFT = 30;
    localparam int QUO_W        = WEIGHT_SHIFT + 1;
    localparam int BITCNT_W     = $clog2(QUO_W);

    localparam int SLOT_W = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
    localparam int NF_W   = $clog2(MAX_CLUSTERS + 1);
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [DIST_W-1:0]   MAX_DISTANCE_RESET = DIST_W'(16);
    localparam logic [WEIGHT_W-1:0] WEIGHT_ZERO_DIST   = {WEIGHT_W{1'b1}};
    localparam logic [TALLY_W-1:0]  TALLY_MAX          = {TALLY_W{1'b1}};

    // one classified neighbor handed from front to back
    typedef struct packed {
        logic                qual;
        logic                ends;
        logic [CL_W-1:0]     cluster;
        logic [WEIGHT_W-1:0] weight;
    } vote_entry_t;

endpackage

>>> design/wncv_front.sv
`timescale 1ns / 1ps

module wncv_front
    import wncv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  logic              neighbor_valid,
    input  logic [CL_W-1:0]   cluster_id,
    input  logic [DIST_W-1:0] distance,
    input  logic              last,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [DIST_W-1:0] cfg_data,
    input  logic              q_full,
    output logic              q_push,
    output vote_entry_t       q_entry
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_PUSH
    } front_state_t;

    front_state_t         state_reg;
    logic [DIST_W-1:0]    max_distance_reg;
    logic [DIST_W-1:0]    dist_reg;
    logic [SQ_W-1:0]      sq_reg;
    logic [SQ_W-1:0]      rem_reg;
    logic [QUO_W-1:0]     quo_reg;
    logic [BITCNT_W-1:0]  bit_cnt_reg;
    vote_entry_t          entry_reg;

    logic                 accept;
    logic                 qualifies;
    logic [SQ_W:0]        shifted;
    logic                 sub_ok;
    logic [SQ_W:0]        rem_diff;

    assign cfg_ready  = 1'b1;
    assign item_stall = (state_reg != ST_IDLE);
    assign accept     = item_valid && !item_stall;
    assign qualifies  = neighbor_valid && (distance < max_distance_reg);

    // restoring step: the dividend is a single one at bit WEIGHT_SHIFT
    assign shifted  = {rem_reg, (bit_cnt_reg == BITCNT_W'(WEIGHT_SHIFT))};
    assign sub_ok   = (shifted >= {1'b0, sq_reg});
    assign rem_diff = shifted - {1'b0, sq_reg};

    assign q_push  = (state_reg == ST_PUSH) && !q_full;
    assign q_entry = entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            max_distance_reg <= MAX_DISTANCE_RESET;
            dist_reg         <= '0;
            sq_reg           <= '0;
            rem_reg          <= '0;
            quo_reg          <= '0;
            bit_cnt_reg      <= '0;
            entry_reg        <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                max_distance_reg <= cfg_data;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        entry_reg.qual    <= qualifies;
                        entry_reg.ends    <= !neighbor_valid || last;
                        entry_reg.cluster <= cluster_id;
                        entry_reg.weight  <= WEIGHT_ZERO_DIST;
                        dist_reg          <= distance;
                        if (qualifies && (distance != '0))
                        begin
                            state_reg <= ST_MUL;
                        end
                        else
                        begin
                            state_reg <= ST_PUSH;
                        end
                    end
                end
                ST_MUL:
                begin
                    sq_reg      <= dist_reg * dist_reg;
                    rem_reg     <= '0;
                    quo_reg     <= '0;
                    bit_cnt_reg <= BITCNT_W'(QUO_W - 1);
                    state_reg   <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (sub_ok)
                    begin
                        rem_reg <= rem_diff[SQ_W-1:0];
                    end
                    else
                    begin
                        rem_reg <= shifted[SQ_W-1:0];
                    end
                    quo_reg <= {quo_reg[QUO_W-2:0], sub_ok};
                    if (bit_cnt_reg == '0)
                    begin
                        entry_reg.weight <= WEIGHT_W'({quo_reg[QUO_W-2:0], sub_ok});
                        state_reg        <= ST_PUSH;
                    end
                    else
                    begin
                        bit_cnt_reg <= bit_cnt_reg - BITCNT_W'(1);
                    end
                end
                ST_PUSH:
                begin
                    if (!q_full)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> design/wncv_queue.sv
`timescale 1ns / 1ps
`include "weighted_neighbor_cluster_vote_core_macros.svh"

module wncv_queue
    import wncv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  vote_entry_t push_entry,
    output logic        full,
    input  logic        pop,
    output logic        head_valid,
    output vote_entry_t head_entry
);

    vote_entry_t         slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = slots_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                slots_reg[wr_ptr_reg] <= push_entry;
                if (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1))
                begin
                    wr_ptr_reg <= '0;
                end
                else
                begin
                    wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
                end
            end
            if (pop)
            begin
                if (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1))
                begin
                    rd_ptr_reg <= '0;
                end
                else
                begin
                    rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
                end
            end
        end
    end

    `WNCV_ASSERT_NOW(a_no_push_when_full, push, !full)
    `WNCV_ASSERT_NOW(a_no_pop_when_empty, pop, head_valid)
    `WNCV_ASSERT_NEXT(a_push_fills, push && !pop, count_reg != '0)

endmodule

>>> design/wncv_back.sv
`timescale 1ns / 1ps

module wncv_back
    import wncv_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  vote_entry_t     head_entry,
    output logic            pop,
    output logic            result_valid,
    input  logic            result_stall,
    output logic [CL_W-1:0] chosen_cluster,
    output logic            is_new,
    output logic            out_of_clusters
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_UPD,
        ST_DECIDE
    } back_state_t;

    back_state_t          state_reg;
    vote_entry_t          ent_reg;
    logic                 used_reg    [MAX_NEIGHBORS];
    logic [CL_W-1:0]      tcl_reg     [MAX_NEIGHBORS];
    logic [TALLY_W-1:0]   tw_reg      [MAX_NEIGHBORS];
    logic [TALLY_W-1:0]   best_weight_reg;
    logic [CL_W-1:0]      best_cluster_reg;
    logic                 best_found_reg;
    logic [NF_W-1:0]      next_free_reg;
    logic                 slot_ok_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic [TALLY_W-1:0]   sum_reg;
    logic                 res_valid_reg;
    logic [CL_W-1:0]      res_cluster_reg;
    logic                 res_new_reg;
    logic                 res_full_reg;

    logic                 hit_found;
    logic [SLOT_W-1:0]    hit_idx;
    logic                 free_found;
    logic [SLOT_W-1:0]    free_idx;
    logic [TALLY_W-1:0]   base;
    logic [TALLY_W:0]     sum_wide;
    logic                 better;

    assign pop             = (state_reg == ST_IDLE) && head_valid;
    assign result_valid    = res_valid_reg;
    assign chosen_cluster  = res_cluster_reg;
    assign is_new          = res_new_reg;
    assign out_of_clusters = res_full_reg;

    // first matching slot, else first unused slot
    always_comb
    begin
        hit_found  = 1'b0;
        hit_idx    = '0;
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = 0; i < MAX_NEIGHBORS; i++)
        begin
            if (used_reg[i] && (tcl_reg[i] == ent_reg.cluster) && !hit_found)
            begin
                hit_found = 1'b1;
                hit_idx   = SLOT_W'(i);
            end
            if (!used_reg[i] && !free_found)
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    assign base     = hit_found ? tw_reg[hit_idx] : '0;
    assign sum_wide = {1'b0, base} + (TALLY_W + 1)'(ent_reg.weight);
    assign better   = !best_found_reg || (sum_reg > best_weight_reg) ||
                      ((sum_reg == best_weight_reg) && (ent_reg.cluster > best_cluster_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            ent_reg          <= '0;
            for (int i = 0; i < MAX_NEIGHBORS; i++)
            begin
                used_reg[i] <= 1'b0;
                tcl_reg[i]  <= '0;
                tw_reg[i]   <= '0;
            end
            best_weight_reg  <= '0;
            best_cluster_reg <= '0;
            best_found_reg   <= 1'b0;
            next_free_reg    <= '0;
            slot_ok_reg      <= 1'b0;
            slot_reg         <= '0;
            sum_reg          <= '0;
            res_valid_reg    <= 1'b0;
            res_cluster_reg  <= '0;
            res_new_reg      <= 1'b0;
            res_full_reg     <= 1'b0;
        end
        else
        begin
            if (res_valid_reg && !result_stall)
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (head_valid)
                    begin
                        ent_reg <= head_entry;
                        if (head_entry.qual)
                        begin
                            state_reg <= ST_LOOK;
                        end
                        else if (head_entry.ends)
                        begin
                            state_reg <= ST_DECIDE;
                        end
                    end
                end
                ST_LOOK:
                begin
                    slot_ok_reg <= hit_found || free_found;
                    slot_reg    <= hit_found ? hit_idx : free_idx;
                    sum_reg     <= sum_wide[TALLY_W] ? TALLY_MAX : sum_wide[TALLY_W-1:0];
                    state_reg   <= ST_UPD;
                end
                ST_UPD:
                begin
                    // a full table drops a neighbor of an unseen cluster
                    if (slot_ok_reg)
                    begin
                        used_reg[slot_reg] <= 1'b1;
                        tcl_reg[slot_reg]  <= ent_reg.cluster;
                        tw_reg[slot_reg]   <= sum_reg;
                        if (better)
                        begin
                            best_weight_reg  <= sum_reg;
                            best_cluster_reg <= ent_reg.cluster;
                            best_found_reg   <= 1'b1;
                        end
                    end
                    state_reg <= ent_reg.ends ? ST_DECIDE : ST_IDLE;
                end
                ST_DECIDE:
                begin
                    if (!res_valid_reg)
                    begin
                        res_valid_reg <= 1'b1;
                        if (best_found_reg)
                        begin
                            res_cluster_reg <= best_cluster_reg;
                            res_new_reg     <= 1'b0;
                            res_full_reg    <= 1'b0;
                        end
                        else if (next_free_reg < NF_W'(MAX_CLUSTERS))
                        begin
                            res_cluster_reg <= next_free_reg[CL_W-1:0];
                            res_new_reg     <= 1'b1;
                            res_full_reg    <= 1'b0;
                            next_free_reg   <= next_free_reg + NF_W'(1);
                        end
                        else
                        begin
                            res_cluster_reg <= CL_W'(MAX_CLUSTERS - 1);
                            res_new_reg     <= 1'b0;
                            res_full_reg    <= 1'b1;
                        end
                        for (int i = 0; i < MAX_NEIGHBORS; i++)
                        begin
                            used_reg[i] <= 1'b0;
                        end
                        best_found_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> design/weighted_neighbor_cluster_vote_core.sv
`timescale 1ns / 1ps
// channel   handshake             payload
// item      item_valid/stall      neighbor_valid, cluster_id, distance, last
// result    result_valid/stall    chosen_cluster, is_new, out_of_clusters
// cfg       cfg_valid/ready       cfg_data (max_distance)
//
// a qualifying neighbor with nonzero distance holds the front through its states:
// the accept, a squaring step, 31 steps of the bit-serial divider, then the push
// other neighbors go straight from the accept to the push
// reset leaves max_distance at 16, empty tallies and the id counter at 0
// result_stall holds the back, the short queue then fills and stalls the front

module weighted_neighbor_cluster_vote_core
    import wncv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  logic              neighbor_valid,
    input  logic [CL_W-1:0]   cluster_id,
    input  logic [DIST_W-1:0] distance,
    input  logic              last,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [DIST_W-1:0] cfg_data,
    output logic              result_valid,
    input  logic              result_stall,
    output logic [CL_W-1:0]   chosen_cluster,
    output logic              is_new,
    output logic              out_of_clusters
);

    logic        q_full;
    logic        q_push;
    vote_entry_t q_entry;
    logic        q_pop;
    logic        q_head_valid;
    vote_entry_t q_head;

    wncv_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .neighbor_valid (neighbor_valid),
        .cluster_id     (cluster_id),
        .distance       (distance),
        .last           (last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_entry        (q_entry)
    );

    wncv_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_entry (q_head)
    );

    wncv_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head_valid      (q_head_valid),
        .head_entry      (q_head),
        .pop             (q_pop),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .chosen_cluster  (chosen_cluster),
        .is_new          (is_new),
        .out_of_clusters (out_of_clusters)
    );

endmodule

>>> dv/weighted_neighbor_cluster_vote_core_tb.sv
`timescale 1ns / 1ps

import wncv_pkg::*;

typedef struct {
    logic [CL_W-1:0] cluster;
    logic            is_new;
    logic            full;
} cluster_decision_t;

// predicts the cluster decision for each list of neighbors and checks the result beats
class cluster_vote_scoreboard;
    cluster_decision_t   decisions[$];
    logic [DIST_W-1:0]   max_dist;
    logic [CL_W-1:0]     slot_cluster[MAX_NEIGHBORS];
    logic [TALLY_W-1:0]  slot_weight[MAX_NEIGHBORS];
    bit                  slot_used[MAX_NEIGHBORS];
    logic [TALLY_W-1:0]  lead_weight;
    logic [CL_W-1:0]     lead_cluster;
    bit                  lead_found;
    int unsigned         next_free;
    int                  mismatches;

    function new();
        max_dist   = MAX_DISTANCE_RESET;
        next_free  = 0;
        mismatches = 0;
        clear_tally();
    endfunction

    function void clear_tally();
        for (int i = 0; i < MAX_NEIGHBORS; i++)
        begin
            slot_cluster[i] = '0;
            slot_weight[i]  = '0;
            slot_used[i]    = 1'b0;
        end
        lead_weight  = '0;
        lead_cluster = '0;
        lead_found   = 1'b0;
    endfunction

    function void note_item(bit nv, logic [CL_W-1:0] cl, logic [DIST_W-1:0] d, bit lst);
        int                  slot;
        logic [SQ_W-1:0]     sq;
        logic [WEIGHT_W-1:0] w;
        logic [TALLY_W:0]    sum;
        cluster_decision_t   dec;
        if (nv && d < max_dist)
        begin
            slot = -1;
            for (int i = 0; i < MAX_NEIGHBORS; i++)
                if (slot < 0 && slot_used[i] && slot_cluster[i] == cl)
                    slot = i;
            for (int i = 0; i < MAX_NEIGHBORS; i++)
                if (slot < 0 && !slot_used[i])
                begin
                    slot            = i;
                    slot_used[i]    = 1'b1;
                    slot_cluster[i] = cl;
                    slot_weight[i]  = '0;
                end
            // a new cluster with every slot taken is dropped
            if (slot >= 0)
            begin
                if (d == 0)
                    w = WEIGHT_ZERO_DIST;
                else
                begin
                    sq = SQ_W'(d) * SQ_W'(d);
                    w  = WEIGHT_W'((64'd1 << WEIGHT_SHIFT) / 64'(sq));
                end
                sum = {1'b0, slot_weight[slot]} + (TALLY_W + 1)'(w);
                if (sum > {1'b0, TALLY_MAX})
                    sum = {1'b0, TALLY_MAX};
                slot_weight[slot] = sum[TALLY_W-1:0];
                if (!lead_found || sum[TALLY_W-1:0] > lead_weight ||
                    (sum[TALLY_W-1:0] == lead_weight && cl > lead_cluster))
                begin
                    lead_weight  = sum[TALLY_W-1:0];
                    lead_cluster = cl;
                    lead_found   = 1'b1;
                end
            end
        end
        // an invalid beat always closes the list
        if (nv && !lst)
            return;
        dec.is_new = 1'b0;
        dec.full   = 1'b0;
        if (lead_found)
            dec.cluster = lead_cluster;
        else if (next_free < MAX_CLUSTERS)
        begin
            dec.cluster = CL_W'(next_free);
            dec.is_new  = 1'b1;
            next_free++;
        end
        else
        begin
            dec.cluster = CL_W'(MAX_CLUSTERS - 1);
            dec.full    = 1'b1;
        end
        clear_tally();
        decisions.insert(decisions.size(), dec);
    endfunction

    function void check_result(logic [CL_W-1:0] cl, logic nw, logic oc);
        cluster_decision_t want;
        if (decisions.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: cluster %0d is_new %0b out_of_clusters %0b",
                         cl, nw, oc);
            return;
        end
        want = decisions.pop_front();
        if (want.cluster !== cl || want.is_new !== nw || want.full !== oc)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected cluster %0d is_new %0b out_of_clusters %0b,",
                         want.cluster, want.is_new, want.full,
                         " got cluster %0d is_new %0b out_of_clusters %0b",
                         cl, nw, oc);
        end
    endfunction
endclass

module weighted_neighbor_cluster_vote_core_tb;

    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE      = 64;

    logic              clk            = 1'b0;
    logic              rst_n          = 1'b0;
    logic              item_valid     = 1'b0;
    logic              item_stall;
    logic              neighbor_valid = 1'b0;
    logic [CL_W-1:0]   cluster_id     = '0;
    logic [DIST_W-1:0] distance       = '0;
    logic              last           = 1'b0;
    logic              cfg_valid      = 1'b0;
    logic              cfg_ready;
    logic [DIST_W-1:0] cfg_data       = '0;
    logic              result_valid;
    logic              result_stall   = 1'b0;
    logic [CL_W-1:0]   chosen_cluster;
    logic              is_new;
    logic              out_of_clusters;

    cluster_vote_scoreboard sb;
    int send_idle  = 8;
    int recv_idle  = 63;
    int item_count = 0;

    weighted_neighbor_cluster_vote_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .neighbor_valid  (neighbor_valid),
        .cluster_id      (cluster_id),
        .distance        (distance),
        .last            (last),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .chosen_cluster  (chosen_cluster),
        .is_new          (is_new),
        .out_of_clusters (out_of_clusters)
    );

    always #6 clk = ~clk;

    // result side: check accepted beats, then pick next cycle's stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
                sb.check_result(chosen_cluster, is_new, out_of_clusters);
            result_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("TB_ERROR");
        $finish;
    end

    task automatic send_item(bit nv, logic [CL_W-1:0] cl, logic [DIST_W-1:0] d, bit lst);
        while ($urandom_range(99) < send_idle)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid     <= 1'b1;
        neighbor_valid <= nv;
        cluster_id     <= cl;
        distance       <= d;
        last           <= lst;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sb.note_item(nv, cl, d, lst);
        item_count++;
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        while (sb.decisions.size() != 0)
            @(posedge clk);
        // margin before the next register write
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_cfg(logic [DIST_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid   <= 1'b0;
        sb.max_dist = v;
    endtask

    function automatic logic [DIST_W-1:0] pick_distance();
        int m;
        int r;
        int v;
        m = sb.max_dist;
        r = $urandom_range(9);
        if (r == 0)
            v = 0;
        else if (r <= 5)
            v = (m > 0) ? $urandom_range(m - 1) : 0;
        else if (r <= 7)
        begin
            v = m - 1 + $urandom_range(2);
            if (v < 0)
                v = 0;
            if (v > 65535)
                v = 65535;
        end
        else
            v = $urandom_range(65535);
        return DIST_W'(v);
    endfunction

    task automatic send_random_list();
        int              len;
        int              pick;
        bit              broken;
        logic [CL_W-1:0] base;
        logic [CL_W-1:0] cl;
        len  = $urandom_range(1, 6);
        pick = $urandom_range(99);
        base = CL_W'($urandom);
        if (pick < 6)
        begin
            send_item(1'b0, CL_W'($urandom), DIST_W'($urandom), 1'($urandom));
            return;
        end
        broken = (pick < 12);
        for (int k = 0; k < len; k++)
        begin
            // mostly a few nearby ids so that tallies add up and tie
            cl = ($urandom_range(3) == 0) ? CL_W'($urandom) : base + CL_W'($urandom_range(4));
            send_item(1'b1, cl, pick_distance(), (k == len - 1) && !broken);
        end
        if (broken)
            send_item(1'b0, CL_W'($urandom), DIST_W'($urandom), 1'($urandom));
    endtask

    task automatic random_phase(int count);
        int start;
        start = item_count;
        while (item_count - start < count)
        begin
            send_random_list();
            if ($urandom_range(39) == 0)
                drain();
        end
        drain();
    endtask

    initial
    begin
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list, and an invalid beat closing a list without last
        send_item(1'b0, 10'h3FF, 16'hFFFF, 1'b0);
        send_item(1'b1, 10'd7, 16'd0, 1'b0);
        send_item(1'b0, 10'd0, 16'd0, 1'b0);
        // threshold boundary
        send_item(1'b1, 10'h3FF, 16'd16, 1'b0);
        send_item(1'b1, 10'd0, 16'd15, 1'b1);
        // equal weight goes to the larger id
        send_item(1'b1, 10'd9, 16'd4, 1'b0);
        send_item(1'b1, 10'd5, 16'd4, 1'b1);
        // fifth distinct cluster finds no free slot
        for (int i = 1; i <= 4; i++)
            send_item(1'b1, CL_W'(i), 16'd8, 1'b0);
        send_item(1'b1, 10'd6, 16'd0, 1'b1);
        // both tallies saturate, the larger id wins the tie
        repeat (5) send_item(1'b1, 10'd100, 16'd0, 1'b0);
        repeat (4) send_item(1'b1, 10'd200, 16'd0, 1'b0);
        send_item(1'b1, 10'd200, 16'd1, 1'b1);
        drain();

        // weights that floor to zero still vote
        write_cfg(16'hFFFF);
        send_item(1'b1, 10'd50, 16'd40000, 1'b0);
        send_item(1'b1, 10'd30, 16'd65534, 1'b1);
        send_item(1'b1, 10'd31, 16'hFFFF, 1'b1);
        drain();

        write_cfg(16'd300);
        random_phase(280);

        send_idle = 63;
        recv_idle = 8;
        write_cfg(16'hFFFF);
        random_phase(280);

        send_idle = 0;
        recv_idle = 0;
        write_cfg(DIST_W'($urandom_range(1, 4000)));
        random_phase(280);

        // nothing qualifies: every list takes a fresh id
        write_cfg(16'd0);
        repeat (10) send_random_list();
        drain();

        if (sb.mismatches == 0 && sb.decisions.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> files.f
+incdir+design
design/wncv_pkg.sv
design/wncv_front.sv
design/wncv_queue.sv
design/wncv_back.sv
design/weighted_neighbor_cluster_vote_core.sv
dv/weighted_neighbor_cluster_vote_core_tb.sv
